/* hdl/sftpattr_pkg.sv */
// Shared types, constants and helpers for the SFTP attribute block parser.
package sftpattr_pkg;

   // Attribute flag bits
   localparam logic [31:0] FLAG_SIZE     = 32'h0000_0001;
   localparam logic [31:0] FLAG_UIDGID   = 32'h0000_0002;
   localparam logic [31:0] FLAG_PERMS    = 32'h0000_0004;
   localparam logic [31:0] FLAG_ACMOD    = 32'h0000_0008;
   localparam logic [31:0] FLAG_EXTENDED = 32'h8000_0000;

   // Field lengths in bytes
   localparam logic [3:0] WIDE_FIELD_BYTES   = 4'd8;
   localparam logic [3:0] NARROW_FIELD_BYTES = 4'd4;

   typedef enum logic [3:0] {
      STAGE_FLAGS    = 4'd0,
      STAGE_SIZE     = 4'd1,
      STAGE_UIDGID   = 4'd2,
      STAGE_PERMS    = 4'd3,
      STAGE_ATIME    = 4'd4,
      STAGE_MTIME    = 4'd5,
      STAGE_EXTCOUNT = 4'd6,
      STAGE_TYPELEN  = 4'd7,
      STAGE_TYPEDATA = 4'd8,
      STAGE_DATALEN  = 4'd9,
      STAGE_DATADATA = 4'd10,
      STAGE_DONE     = 4'd11
   } stage_type;

   typedef struct packed {
      logic [31:0] attr_flags;
      logic [63:0] file_size;
      logic [31:0] permissions;
      logic [31:0] access_time;
      logic [31:0] modify_time;
      logic        parse_ok;
   } result_type;

   // Skip optional fields whose flag bit is clear
   function automatic stage_type settle_stage(stage_type s, logic [31:0] flags);
      stage_type r;
      r = s;
      if (r == STAGE_SIZE && (flags & FLAG_SIZE) == '0) r = STAGE_UIDGID;
      if (r == STAGE_UIDGID && (flags & FLAG_UIDGID) == '0) r = STAGE_PERMS;
      if (r == STAGE_PERMS && (flags & FLAG_PERMS) == '0) r = STAGE_ATIME;
      if (r == STAGE_ATIME && (flags & FLAG_ACMOD) == '0) r = STAGE_EXTCOUNT;
      if (r == STAGE_EXTCOUNT && (flags & FLAG_EXTENDED) == '0) r = STAGE_DONE;
      return r;
   endfunction

   // Byte length of the field read in a stage
   function automatic logic [3:0] field_bytes(stage_type s);
      return (s == STAGE_SIZE || s == STAGE_UIDGID) ? WIDE_FIELD_BYTES
                                                    : NARROW_FIELD_BYTES;
   endfunction

endpackage

/* hdl/sftp_attrs_stream_parser_top.sv */
// Top level of the SFTP v3 attribute block parser with its output skid stage.
//
// Usage:
//   req_ channel: one payload byte per request (req_data_byte), with
//   req_end_of_payload high on the last byte of the payload. A request is
//   taken at a clock edge where req_valid is high and req_stall is low.
//   rsp_ channel: one result per attribute block, carrying the flags, size,
//   permissions, access and modify times and rsp_parse_ok. A result is
//   given when the block completes (ok set) or when the payload ends first
//   (ok clear, fields cut off read as zero). Bytes after completion up to
//   the end mark give nothing.
//   Throughput: one byte per cycle while req_stall is low; each byte is
//   one pass through the parse step between the parse state registers and
//   the result register, which drives rsp_.
//   Stall: a one-entry skid register catches a result while rsp_stall is
//   high; req_stall rises only once that skid entry is occupied.
//   Reset: synchronous; the parse returns to the flags word and no result
//   is pending. The end mark also returns the parse to its start.
module sftp_attrs_stream_parser_top
   import sftpattr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_attr_flags,
   output logic [63:0] rsp_file_size,
   output logic [31:0] rsp_permissions,
   output logic [31:0] rsp_access_time,
   output logic [31:0] rsp_modify_time,
   output logic        rsp_parse_ok
);

   logic       req_take;
   logic       res_valid;
   result_type res;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_take;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid & ~req_stall;
   assign out_take  = out_valid_ff & ~rsp_stall;

   sftpattr_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .take      (req_take),
      .data_byte (req_data_byte),
      .last      (req_end_of_payload),
      .res_valid (res_valid),
      .res       (res)
   );

   // Route results through the output and skid registers
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (!out_valid_ff || out_take) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   // Hold handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Hold result payloads
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_attr_flags  = out_ff.attr_flags;
   assign rsp_file_size   = out_ff.file_size;
   assign rsp_permissions = out_ff.permissions;
   assign rsp_access_time = out_ff.access_time;
   assign rsp_modify_time = out_ff.modify_time;
   assign rsp_parse_ok    = out_ff.parse_ok;

   // Skid entry is only used behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without output entry");

   // Skid fills only from a new result meeting a stalled output
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !$past(skid_valid_ff))
         |-> $past(res_valid && out_valid_ff && rsp_stall))
      else $error("skid filled without a stalled result");

endmodule

/* hdl/sftpattr_parse.sv */
// Byte-wise parse state and result decision for one attribute block.
module sftpattr_parse
   import sftpattr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] data_byte,
   input  logic       last,
   output logic       res_valid,
   output result_type res
);

   stage_type   stage_ff, stage_in;
   logic [3:0]  count_ff, count_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] flags_ff, flags_in;
   logic [63:0] size_ff, size_in;
   logic [31:0] perms_ff, perms_in;
   logic [31:0] atime_ff, atime_in;
   logic [31:0] mtime_ff, mtime_in;
   logic [31:0] pairs_ff, pairs_in;
   logic [31:0] strleft_ff, strleft_in;
   logic        done_ff, done_in;

   logic [63:0] acc_shift;
   logic [3:0]  count_inc;
   logic [31:0] word;
   logic [31:0] left_dec;
   logic [31:0] pairs_dec;
   logic        clear;

   assign acc_shift = {acc_ff[55:0], data_byte};
   assign count_inc = count_ff + 4'd1;
   assign word      = acc_shift[31:0];
   assign left_dec  = strleft_ff - 32'd1;
   assign pairs_dec = pairs_ff - 32'd1;

   // Advance the parse by one request byte and decide on a result
   always_comb begin
      stage_in   = stage_ff;
      count_in   = count_ff;
      acc_in     = acc_ff;
      flags_in   = flags_ff;
      size_in    = size_ff;
      perms_in   = perms_ff;
      atime_in   = atime_ff;
      mtime_in   = mtime_ff;
      pairs_in   = pairs_ff;
      strleft_in = strleft_ff;
      done_in    = done_ff;
      clear      = 1'b0;
      res_valid  = 1'b0;
      res        = '0;

      if (take) begin
         if (!done_ff) begin
            if (stage_ff == STAGE_TYPEDATA || stage_ff == STAGE_DATADATA) begin
               // skip string bytes
               strleft_in = left_dec;
               if (left_dec == '0) begin
                  if (stage_ff == STAGE_TYPEDATA) begin
                     stage_in = STAGE_DATALEN;
                  end else begin
                     pairs_in = pairs_dec;
                     stage_in = (pairs_dec == '0) ? STAGE_DONE : STAGE_TYPELEN;
                  end
               end
            end else if (stage_ff > STAGE_DATALEN) begin
               stage_in = STAGE_DONE;
            end else if (count_inc < field_bytes(stage_ff)) begin
               // gather another byte of the current field
               acc_in   = acc_shift;
               count_in = count_inc;
            end else begin
               // field complete: store it and pick the next stage
               acc_in   = '0;
               count_in = '0;
               unique case (stage_ff)
                  STAGE_FLAGS: begin
                     flags_in = word;
                     stage_in = settle_stage(STAGE_SIZE, word);
                  end
                  STAGE_SIZE: begin
                     size_in  = acc_shift;
                     stage_in = settle_stage(STAGE_UIDGID, flags_ff);
                  end
                  STAGE_UIDGID: begin
                     stage_in = settle_stage(STAGE_PERMS, flags_ff);
                  end
                  STAGE_PERMS: begin
                     perms_in = word;
                     stage_in = settle_stage(STAGE_ATIME, flags_ff);
                  end
                  STAGE_ATIME: begin
                     atime_in = word;
                     stage_in = STAGE_MTIME;
                  end
                  STAGE_MTIME: begin
                     mtime_in = word;
                     stage_in = settle_stage(STAGE_EXTCOUNT, flags_ff);
                  end
                  STAGE_EXTCOUNT: begin
                     pairs_in = word;
                     stage_in = (word == '0) ? STAGE_DONE : STAGE_TYPELEN;
                  end
                  STAGE_TYPELEN: begin
                     strleft_in = word;
                     stage_in   = (word == '0) ? STAGE_DATALEN : STAGE_TYPEDATA;
                  end
                  default: begin
                     // extended data length
                     strleft_in = word;
                     if (word == '0) begin
                        pairs_in = pairs_dec;
                        stage_in = (pairs_dec == '0) ? STAGE_DONE : STAGE_TYPELEN;
                     end else begin
                        stage_in = STAGE_DATADATA;
                     end
                  end
               endcase
            end

            // report on completion, or on an early end of payload
            res.attr_flags  = flags_in;
            res.file_size   = size_in;
            res.permissions = perms_in;
            res.access_time = atime_in;
            res.modify_time = mtime_in;
            if (stage_in == STAGE_DONE) begin
               res_valid    = 1'b1;
               res.parse_ok = 1'b1;
               done_in      = 1'b1;
            end else if (last) begin
               res_valid    = 1'b1;
               res.parse_ok = 1'b0;
            end
         end
         clear = last;
      end

      // drop all parse state at the end of the payload
      if (clear) begin
         stage_in   = STAGE_FLAGS;
         count_in   = '0;
         acc_in     = '0;
         flags_in   = '0;
         size_in    = '0;
         perms_in   = '0;
         atime_in   = '0;
         mtime_in   = '0;
         pairs_in   = '0;
         strleft_in = '0;
         done_in    = 1'b0;
      end
   end

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff   <= STAGE_FLAGS;
         count_ff   <= '0;
         acc_ff     <= '0;
         flags_ff   <= '0;
         size_ff    <= '0;
         perms_ff   <= '0;
         atime_ff   <= '0;
         mtime_ff   <= '0;
         pairs_ff   <= '0;
         strleft_ff <= '0;
         done_ff    <= 1'b0;
      end else begin
         stage_ff   <= stage_in;
         count_ff   <= count_in;
         acc_ff     <= acc_in;
         flags_ff   <= flags_in;
         size_ff    <= size_in;
         perms_ff   <= perms_in;
         atime_ff   <= atime_in;
         mtime_ff   <= mtime_in;
         pairs_ff   <= pairs_in;
         strleft_ff <= strleft_in;
         done_ff    <= done_in;
      end
   end

   // Completed block always parks in the final stage
   a_done_stage: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> stage_ff == STAGE_DONE)
      else $error("completed block outside final stage");

   // Partial field never holds a full field's bytes
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < WIDE_FIELD_BYTES)
      else $error("field byte count out of range");

   // String skip stages always have bytes left to skip
   a_string_left: assert property (@(posedge clock) disable iff (reset)
      (stage_ff == STAGE_TYPEDATA || stage_ff == STAGE_DATADATA)
         |-> strleft_ff != '0)
      else $error("string skip with no bytes left");

   // A result only follows an accepted byte
   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> take)
      else $error("result without request");

endmodule
